@@ sv/wrt_pkg.sv @@
// Shared widths, register indexes, reset values and payload types for the
// windowed rate throttle. No dependencies; every other file but wrt_chan_if imports this one.
`timescale 1ns / 1ps
`default_nettype none

package wrt_pkg;

   localparam int TIME_W    = 48;
   localparam int PERIOD_W  = 24;
   localparam int SPAN_W    = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;

   localparam int RING_DEPTH_DEF = 64;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd100000;
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = 32'd1000000;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SPAN   = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] frame_time;
   } req_type;

   typedef struct packed {
      logic accept;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/wrt_chan_if.sv @@
// Valid/ready channel carrying one payload item per handshake.
// The payload type is a parameter; the throttle uses the types from wrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wrt_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ sv/wrt_alu.sv @@
// Shared subtract/compare unit of the throttle sequencer.
// Depends on wrt_pkg for the time width.
`timescale 1ns / 1ps
`default_nettype none

module wrt_alu
   import wrt_pkg::*;
(
   input  wire logic [TIME_W-1:0] op_a,
   input  wire logic [TIME_W-1:0] op_b,
   output logic      [TIME_W-1:0] diff,
   output logic                   borrow
);

   // A borrow out means op_a is smaller than op_b.
   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

`default_nettype wire

@@ sv/wrt_ring.sv @@
// Timestamp ring storage: one write port and one registered read port.
// Depends on wrt_pkg for the time width.
`timescale 1ns / 1ps
`default_nettype none

module wrt_ring
   import wrt_pkg::*;
#(
   parameter int DEPTH = RING_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [PTR_W-1:0]  wr_addr,
   input  wire logic [TIME_W-1:0] wr_data,
   input  wire logic [PTR_W-1:0]  rd_addr,
   output logic      [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/windowed_rate_throttle.sv @@
// Top level of the windowed rate throttle: sequencer, registers and output stage.
// Depends on wrt_pkg, wrt_chan_if, wrt_alu and wrt_ring.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload             Handshake
// req_ch    in         frame_time (48 b)   valid/ready, taken when both high
// rsp_ch    out        accept (1 b)        valid/ready, taken when both high
// csr_*     in         index, 32 b data    write when csr_wr_en is high
//
// One shared 48-bit subtract unit runs under a sequencer. An earlier timestamp is
// dropped after the order check, and a frame dropped on the average after the span
// and judge steps; the first frame is pushed at once. An accepted frame is pushed
// and then pops entries, each pop a subtract, a compare and a ring read; a full ring
// pops one entry before the push, and the pops stop once one entry is left. Input is
// ready again in the same cycle that rsp valid rises.
// Reset (synchronous, active high) empties the ring and restores the register
// defaults; ring contents need no clearing because only covered entries are read.
// A result waits in the output register while the next item is accepted; only
// the final hand-off of a later result waits for the output to drain.

module windowed_rate_throttle
   import wrt_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   wrt_chan_if.sink                  req_ch,
   wrt_chan_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int LIM_W = PERIOD_W + CNT_W;

   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_ORDER   = 10'b00_0000_0010,
      S_SPAN    = 10'b00_0000_0100,
      S_JUDGE   = 10'b00_0000_1000,
      S_FULLPOP = 10'b00_0001_0000,
      S_PUSH    = 10'b00_0010_0000,
      S_WDIFF   = 10'b00_0100_0000,
      S_WCMP    = 10'b00_1000_0000,
      S_POP     = 10'b01_0000_0000,
      S_RESULT  = 10'b10_0000_0000
   } state_type;

   // Control state.
   state_type           state_ff, state_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                out_valid_ff, out_valid_in;

   // Datapath registers.
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   newest_ff, newest_in;
   logic [TIME_W-1:0]   oldest_ff, oldest_in;
   logic [TIME_W-1:0]   scratch_ff, scratch_in;
   logic [LIM_W-1:0]    limit_ff, limit_in;
   logic                verdict_ff, verdict_in;
   logic                out_accept_ff, out_accept_in;

   // Shared unit and ring wiring.
   logic [TIME_W-1:0]   alu_a, alu_b, alu_diff;
   logic                alu_borrow;
   logic                ring_wr_en;
   logic [PTR_W-1:0]    ring_wr_addr, ring_rd_addr, head_next;
   logic [PTR_W:0]      slot_sum;
   logic [TIME_W-1:0]   ring_rd_data;
   logic                req_take, rsp_take;

   wrt_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   wrt_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (time_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // The read port always looks at the entry after the oldest one, so the
   // next oldest timestamp is ready when a pop needs it.
   assign head_next    = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign ring_rd_addr = head_next;

   // The write slot, one past the newest, is head plus count, wrapped once.
   assign slot_sum     = {1'b0, head_ff} + (PTR_W + 1)'(count_ff);
   assign ring_wr_addr = (slot_sum >= DEPTH_EXT) ? PTR_W'(slot_sum - DEPTH_EXT)
                                                 : PTR_W'(slot_sum);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.data.accept = out_accept_ff;

   // Operand selection for the shared subtractor.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         S_ORDER: begin
            alu_a = time_ff;
            alu_b = newest_ff;
         end
         S_SPAN: begin
            alu_a = time_ff;
            alu_b = oldest_ff;
         end
         S_JUDGE: begin
            alu_a = TIME_W'(limit_ff);
            alu_b = scratch_ff;
         end
         S_WDIFF: begin
            alu_a = newest_ff;
            alu_b = oldest_ff;
         end
         S_WCMP: begin
            alu_a = TIME_W'(span_ff);
            alu_b = scratch_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      span_in       = span_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      scratch_in    = scratch_ff;
      limit_in      = limit_ff;
      verdict_in    = verdict_ff;
      out_accept_in = out_accept_ff;
      out_valid_in  = out_valid_ff && !rsp_take;
      ring_wr_en    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TARGET_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            REG_WINDOW_SPAN:   span_in   = csr_wdata[SPAN_W-1:0];
            default:           ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               time_in = req_ch.data.frame_time;
               // The first frame into an empty ring is always kept.
               if (count_ff == '0) begin
                  verdict_in = 1'b1;
                  state_in   = S_PUSH;
               end else begin
                  state_in = S_ORDER;
               end
            end
         end
         S_ORDER: begin
            // A frame older than the newest stored one is dropped untouched.
            if (alu_borrow) begin
               verdict_in = 1'b0;
               state_in   = S_RESULT;
            end else begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            // Interval sum plus the new interval equals frame time minus oldest.
            scratch_in = alu_diff;
            limit_in   = LIM_W'(period_ff) * LIM_W'(count_ff);
            state_in   = S_JUDGE;
         end
         S_JUDGE: begin
            // Keep the frame only when the sum exceeds period times count.
            if (!alu_borrow) begin
               verdict_in = 1'b0;
               state_in   = S_RESULT;
            end else begin
               verdict_in = 1'b1;
               state_in   = (count_ff == CNT_FULL) ? S_FULLPOP : S_PUSH;
            end
         end
         S_FULLPOP: begin
            oldest_in = ring_rd_data;
            head_in   = head_next;
            count_in  = count_ff - CNT_W'(1);
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            ring_wr_en = 1'b1;
            newest_in  = time_ff;
            if (count_ff == '0) begin
               oldest_in = time_ff;
            end
            count_in = count_ff + CNT_W'(1);
            state_in = S_WDIFF;
         end
         S_WDIFF: begin
            if (count_ff < CNT_TWO) begin
               state_in = S_RESULT;
            end else begin
               scratch_in = alu_diff;
               state_in   = S_WCMP;
            end
         end
         S_WCMP: begin
            // Pop while the stored span is wider than the window.
            state_in = alu_borrow ? S_POP : S_RESULT;
         end
         S_POP: begin
            oldest_in = ring_rd_data;
            head_in   = head_next;
            count_in  = count_ff - CNT_W'(1);
            state_in  = S_WDIFF;
         end
         S_RESULT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in  = 1'b1;
               out_accept_in = verdict_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_RESET;
         span_ff      <= SPAN_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         span_ff      <= span_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      newest_ff     <= newest_in;
      oldest_ff     <= oldest_in;
      scratch_ff    <= scratch_in;
      limit_ff      <= limit_in;
      verdict_ff    <= verdict_in;
      out_accept_ff <= out_accept_in;
   end

endmodule

`default_nettype wire

@@ sim/wrt_checker.sv @@
// Checker for the windowed rate throttle: watches the frame, verdict and register ports,
// predicts each verdict, and compares it with what the block returns.
// Depends on wrt_pkg.
`timescale 1ns / 1ps

module wrt_checker
   import wrt_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [TIME_W-1:0]    req_frame_time,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_accept,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   pending,
   output int                   fail_count
);

   typedef struct {
      logic [TIME_W-1:0] frame_time;
      bit                accept;
   } verdict_type;

   // Shadow copy of the registers and of the timestamp ring.
   logic [PERIOD_W-1:0] period;
   logic [SPAN_W-1:0]   span;
   logic [TIME_W-1:0]   stamps [RING_DEPTH];
   int unsigned         head;
   int unsigned         stored;
   logic [TIME_W-1:0]   gap_sum;

   verdict_type expected_verdicts [$];
   int unsigned verdicts_seen;

   initial begin
      pending    = 0;
      fail_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int unsigned slot(input int unsigned k);
      return (head + k) % RING_DEPTH;
   endfunction

   function automatic void drop_oldest();
      gap_sum = gap_sum - (stamps[slot(1)] - stamps[slot(0)]);
      head    = slot(1);
      stored--;
   endfunction

   function automatic void store_time(input logic [TIME_W-1:0] t);
      stamps[slot(stored)] = t;
      stored++;
   endfunction

   // Judges one frame and updates the shadow ring the way the block does.
   function automatic bit judge_frame(input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] last;
      logic [TIME_W-1:0] dt;
      logic [TIME_W:0]   total;
      logic [TIME_W:0]   limit;
      if (stored == 0) begin
         store_time(t);
         return 1'b1;
      end
      last = stamps[slot(stored - 1)];
      if (t < last) begin
         return 1'b0;
      end
      dt    = t - last;
      total = {1'b0, gap_sum} + {1'b0, dt};
      limit = {25'd0, period} * stored;
      if (total <= limit) begin
         return 1'b0;
      end
      // The judgement above used the count from before this pop.
      if (stored >= RING_DEPTH) begin
         drop_oldest();
      end
      gap_sum = gap_sum + dt;
      store_time(t);
      while (stored >= 2 && (stamps[slot(stored - 1)] - stamps[slot(0)]) > span) begin
         drop_oldest();
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      verdict_type due;
      if (reset) begin
         period        = PERIOD_RESET;
         span          = SPAN_RESET;
         head          = 0;
         stored        = 0;
         gap_sum       = '0;
         verdicts_seen = 0;
         expected_verdicts.delete();
      end else begin
         // Results are taken before frames: a frame accepted on this edge
         // cannot have its verdict out on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0d arrived with no frame outstanding",
                                         verdicts_seen));
            end else begin
               due = expected_verdicts[0];
               expected_verdicts.delete(0);
               if (rsp_accept !== due.accept) begin
                  report_mismatch($sformatf("verdict %0d for frame time %0d: accept %b, want %b",
                                            verdicts_seen, due.frame_time, rsp_accept,
                                            due.accept));
               end
            end
            verdicts_seen++;
         end
         if (req_valid && req_ready) begin
            due.frame_time = req_frame_time;
            due.accept     = judge_frame(req_frame_time);
            expected_verdicts.push_back(due);
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_TARGET_PERIOD: period = csr_wdata[PERIOD_W-1:0];
               REG_WINDOW_SPAN:   span   = csr_wdata[SPAN_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_verdicts.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Top of the windowed rate throttle testbench: clock, reset, frame stimulus, verdict
// back-pressure and the final verdict. Depends on wrt_pkg, wrt_chan_if, wrt_checker
// and the throttle itself.
`timescale 1ns / 1ps

module tb_top
   import wrt_pkg::*;
();

   localparam int CYCLE_LIMIT = 2_000_000;

   // An accepted frame may pop nearly the whole ring, so the block is given this
   // long to go quiet before a register write.
   localparam int SETTLE_CYCLES = 3 * RING_DEPTH_DEF + 16;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   wrt_chan_if #(.payload_type(req_type)) req_ch ();
   wrt_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   int pending;
   int fail_count;
   int cycle_count = 0;

   // Stimulus bookkeeping: how many frames went in, and the latest timestamp
   // offered so far, which well-formed frames build on.
   int unsigned       items_sent  = 0;
   logic [TIME_W-1:0] newest_sent = '0;
   bit                send_steady = 1'b0;
   bit                stall_hold  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   windowed_rate_throttle #(
      .RING_DEPTH(RING_DEPTH_DEF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wrt_checker #(
      .RING_DEPTH(RING_DEPTH_DEF)
   ) verdict_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_frame_time (req_ch.data.frame_time),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_accept     (rsp_ch.data.accept),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending        (pending),
      .fail_count     (fail_count)
   );

   // Idle cycles before the next item. Each side now and then flips into a
   // steady run with no idling, so both bursts and sparse traffic occur.
   function automatic int unsigned draw_idle(inout bit steady);
      if ($urandom_range(0, 39) == 0) begin
         steady = !steady;
      end
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   // Offers one frame and returns on the edge where it is taken. Valid stays
   // high into the next item unless that item starts with idle cycles.
   task automatic send_frame(input logic [TIME_W-1:0] t);
      int unsigned gap;
      gap = draw_idle(send_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.data.frame_time <= t;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (t > newest_sent) begin
         newest_sent = t;
      end
   endtask

   // Waits until every verdict is back, then waits a further SETTLE_CYCLES.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on two consecutive edges; the enable is lowered only
   // once, after the second write.
   task automatic set_rates(input logic [PERIOD_W-1:0] period, input logic [SPAN_W-1:0] span);
      csr_wr_en <= 1'b1;
      csr_index <= REG_TARGET_PERIOD;
      csr_wdata <= CSR_W'(period);
      @(posedge clock);
      csr_index <= REG_WINDOW_SPAN;
      csr_wdata <= CSR_W'(span);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One register setting followed by a stream of frames. Most frames step
   // forward from the latest timestamp by up to step_max; the rest repeat it,
   // fall behind it, or land anywhere in the 48-bit range.
   task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [SPAN_W-1:0] span,
                            input int unsigned n_items, input int unsigned step_max);
      int unsigned       pick;
      logic [TIME_W:0]   ahead;
      logic [TIME_W-1:0] t;
      settle();
      set_rates(period, span);
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            ahead = {1'b0, newest_sent} + (TIME_W + 1)'($urandom_range(0, step_max));
            t     = ahead[TIME_W] ? TIME_MAX : ahead[TIME_W-1:0];
         end else if (pick < 88) begin
            t = newest_sent;
         end else if (pick < 96) begin
            t = newest_sent - TIME_W'($urandom_range(1, step_max + 1));
         end else begin
            t = TIME_W'({$urandom, $urandom});
         end
         send_frame(t);
      end
   endtask

   // Main sequence.
   initial begin
      int unsigned period_pick;
      int unsigned span_pick;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset values (period 100000, span 1000000):
      // the first frame at time zero, an equal timestamp with a zero sum, an
      // earlier timestamp, a sum exactly at the limit and one past it, and a
      // long jump that pops the window down to a single entry.
      send_frame(48'd0);
      send_frame(48'd0);
      send_frame(48'd150000);
      send_frame(48'd100);
      send_frame(48'd150000);
      send_frame(48'd300000);
      send_frame(48'd350000);
      send_frame(48'd400000);
      send_frame(48'd400001);
      send_frame(48'd1500000);
      send_frame(48'd1500000);
      send_frame(48'd1600000);
      send_frame(48'd1600001);
      send_frame(48'd2600001);
      send_frame(48'd2700000);
      send_frame(48'd2600000);

      // Zero period: apart from earlier timestamps, only a zero interval sum is dropped. Tiny window.
      run_phase(24'd0, 32'd50, 80, 20);
      // Period of one and widest window: the ring fills and wraps.
      run_phase(24'd1, 32'hFFFF_FFFF, 150, 4);
      // Zero window: every accepted frame leaves a single entry behind.
      run_phase(24'd5000, 32'd0, 100, 12000);
      // Largest period.
      run_phase(24'hFF_FFFF, 32'hFFFF_FFFF, 100, 2 * 24'hFF_FFFF + 1);

      repeat (5) begin
         period_pick = $urandom_range(1, 200000);
         span_pick   = $urandom_range(0, 40 * period_pick);
         run_phase(PERIOD_W'(period_pick), SPAN_W'(span_pick), 120, 2 * period_pick + 1);
      end

      // The top of the timestamp range comes last, since it would leave every
      // later frame behind.
      send_frame(TIME_MAX);
      settle();

      if (fail_count == 0) begin
         $display("windowed_rate_throttle test passed");
      end else begin
         $display("windowed_rate_throttle test failed");
      end
      $finish;
   end

   // Verdict side: random idling between verdicts, plus a long hold-off while
   // stall_hold is set.
   initial begin
      int unsigned hold;
      bit          steady;
      steady = 1'b0;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_idle(steady);
         if (hold > 0 || stall_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            while (stall_hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Once the run is well under way, the verdict side stops taking results for
   // a long stretch while frames keep coming, so the block backs up and stalls
   // its input. The flag changes on the falling edge so that it is stable
   // whenever the verdict side looks at it.
   initial begin
      wait (items_sent >= 600);
      @(negedge clock);
      stall_hold = 1'b1;
      repeat (400) @(negedge clock);
      stall_hold = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("windowed_rate_throttle test failed");
         $finish;
      end
   end

endmodule
